### design/lz4d_pkg.sv
package lz4d_pkg;

  localparam int unsigned HIST_DEPTH = 65536;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned LEN_W      = 17;

  localparam logic [LEN_W-1:0] HIST_DEPTH_L = LEN_W'(HIST_DEPTH);
  localparam logic [LEN_W-1:0] LEN_MAX      = '1;

  // commands
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_RSVD    = 2'd3;

  // status / outcome
  localparam logic [1:0] ST_RUNNING  = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;
  localparam logic [1:0] ST_REFUSED  = 2'd3;

  // parse phases
  localparam logic [2:0] PH_TOKEN     = 3'd0;
  localparam logic [2:0] PH_LIT_EXT   = 3'd1;
  localparam logic [2:0] PH_LITERALS  = 3'd2;
  localparam logic [2:0] PH_OFF_LO    = 3'd3;
  localparam logic [2:0] PH_OFF_HI    = 3'd4;
  localparam logic [2:0] PH_MATCH_EXT = 3'd5;
  localparam logic [2:0] PH_COPY      = 3'd6;

  typedef struct packed {
    logic               emit;
    logic               tick;
    logic [7:0]         lit;
    logic [HIST_AW-1:0] wr_addr;
    logic [HIST_AW-1:0] rd_addr;
    logic [1:0]         status;
    logic               need_tick;
  } step_t;

  function automatic logic [LEN_W-1:0] sat_add(logic [LEN_W-1:0] a, logic [7:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {{(LEN_W-7){1'b0}}, b};
    return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

endpackage

### design/lz4d_in_if.sv
interface lz4d_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, command, in_byte, in_last, input ready);
  modport sink   (input valid, command, in_byte, in_last, output ready);
endinterface

### design/lz4d_out_if.sv
interface lz4d_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       need_tick;

  modport source (output valid, out_valid, out_byte, status, need_tick, input ready);
  modport sink   (input valid, out_valid, out_byte, status, need_tick, output ready);
endinterface

### design/lz4_block_decompressor_core.sv
// LZ4 block decompressor.
// in_i carries one item per handshake: a compressed byte (command 0), a tick
// that emits one pending match byte (command 1) or a restart (command 2).
// Every accepted item yields exactly one result item on out_o: out_valid and
// out_byte for a produced byte, status (running, finished, error, refused)
// and need_tick while match bytes remain to be ticked out.
// cfg_we_i/cfg_data_i write raw_length, the exact decompressed size expected.
// Latency: the result is presented the cycle after the item is accepted.
// Throughput: one item per cycle while out_o is not stalled, set by the single
// read and single write port of the 64 KiB history RAM; a tick reading the byte
// written by the item just ahead of it is served from a forwarding register.
// Reset clears the parse state, counters, outcome and raw_length; history is
// not cleared and needs no clearing pass. Restart clears the parse likewise
// but keeps raw_length.
// A stalled receiver holds the result register; in_i.ready drops only while
// a result is held and out_o.ready is low.
module lz4_block_decompressor_core import lz4d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lz4d_in_if.sink     in_i,
  lz4d_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  step_t              step;
  logic               accept;
  logic               free;
  logic               ram_we;
  logic [HIST_AW-1:0] ram_waddr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  lz4d_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (in_i.command),
    .in_byte_i  (in_i.in_byte),
    .in_last_i  (in_i.in_last),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .step_o     (step)
  );

  lz4d_ram #(
    .WIDTH (8),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept && step.tick),
    .raddr_i (step.rd_addr),
    .rdata_o (ram_rdata)
  );

  lz4d_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .step_i   (step),
    .free_o   (free),
    .rdata_i  (ram_rdata),
    .we_o     (ram_we),
    .waddr_o  (ram_waddr),
    .wdata_o  (ram_wdata),
    .out_o    (out_o)
  );

endmodule

### design/lz4d_ram.sv
module lz4d_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lz4d_parser.sv
module lz4d_parser import lz4d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  command_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  output step_t       step_o
);

  logic [15:0]      raw_q;
  logic [2:0]       phase_q, phase_d;
  logic [3:0]       nib_q, nib_d;
  logic [LEN_W-1:0] lit_q, lit_d;
  logic [LEN_W-1:0] ml_q, ml_d;
  logic [15:0]      dist_q, dist_d;
  logic [LEN_W-1:0] bw_q, bw_d;
  logic             ended_q, ended_d;
  logic [1:0]       outcome_q, outcome_d;

  logic [LEN_W-1:0] raw_l;
  logic [LEN_W-1:0] room;
  logic [LEN_W-1:0] bw_inc;
  logic [LEN_W-1:0] m4;
  logic [15:0]      dist_new;
  logic [15:0]      src;
  logic             lit_known;
  logic             match_known;
  logic [1:0]       status;

  assign raw_l  = {1'b0, raw_q};
  assign room   = (raw_l > bw_q) ? (raw_l - bw_q) : '0;
  assign bw_inc = bw_q + LEN_W'(1);
  assign src    = bw_q[15:0] - dist_q;
  assign dist_new = {in_byte_i, dist_q[7:0]};

  always_comb begin
    phase_d     = phase_q;
    nib_d       = nib_q;
    lit_d       = lit_q;
    ml_d        = ml_q;
    dist_d      = dist_q;
    bw_d        = bw_q;
    ended_d     = ended_q;
    outcome_d   = outcome_q;
    lit_known   = 1'b0;
    match_known = 1'b0;
    m4          = '0;
    step_o.emit = 1'b0;
    step_o.tick = 1'b0;
    status      = outcome_q;

    if (command_i == CMD_RESTART) begin
      phase_d   = PH_TOKEN;
      nib_d     = '0;
      lit_d     = '0;
      ml_d      = '0;
      dist_d    = '0;
      bw_d      = '0;
      ended_d   = 1'b0;
      outcome_d = ST_RUNNING;
      status    = ST_RUNNING;
    end else if (outcome_q != ST_RUNNING) begin
      status = outcome_q;
    end else if (command_i == CMD_RSVD ||
                 (command_i == CMD_BYTE && phase_q == PH_COPY) ||
                 (command_i == CMD_TICK && phase_q != PH_COPY)) begin
      status = ST_REFUSED;
    end else if (command_i == CMD_BYTE) begin
      unique case (phase_q)
        PH_TOKEN: begin
          nib_d = in_byte_i[3:0];
          lit_d = {{(LEN_W-4){1'b0}}, in_byte_i[7:4]};
          if (in_byte_i[7:4] == 4'hf) begin
            phase_d = PH_LIT_EXT;
            if (in_last_i) outcome_d = ST_ERROR;
          end else begin
            lit_known = 1'b1;
          end
        end
        PH_LIT_EXT: begin
          lit_d = sat_add(lit_q, in_byte_i);
          if (in_byte_i == 8'hff) begin
            if (in_last_i) outcome_d = ST_ERROR;
          end else begin
            lit_known = 1'b1;
          end
        end
        PH_LITERALS: begin
          step_o.emit = 1'b1;
          bw_d  = bw_inc;
          lit_d = lit_q - LEN_W'(1);
          if (lit_q == LEN_W'(1)) begin
            if (in_last_i) begin
              outcome_d = (bw_inc == raw_l) ? ST_FINISHED : ST_ERROR;
            end else begin
              phase_d = PH_OFF_LO;
            end
          end else if (in_last_i) begin
            outcome_d = ST_ERROR;
          end
        end
        PH_OFF_LO: begin
          dist_d  = {8'h00, in_byte_i};
          phase_d = PH_OFF_HI;
          if (in_last_i) outcome_d = ST_ERROR;
        end
        PH_OFF_HI: begin
          dist_d = dist_new;
          if (dist_new == 16'h0000 || {1'b0, dist_new} > bw_q ||
              {1'b0, dist_new} > HIST_DEPTH_L) begin
            outcome_d = ST_ERROR;
          end else if (nib_q == 4'hf) begin
            ml_d    = LEN_W'(15);
            phase_d = PH_MATCH_EXT;
            if (in_last_i) outcome_d = ST_ERROR;
          end else begin
            ml_d        = {{(LEN_W-4){1'b0}}, nib_q};
            match_known = 1'b1;
          end
        end
        PH_MATCH_EXT: begin
          ml_d = sat_add(ml_q, in_byte_i);
          if (in_byte_i == 8'hff) begin
            if (in_last_i) outcome_d = ST_ERROR;
          end else begin
            match_known = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (lit_known) begin
        if (lit_d > room) begin
          outcome_d = ST_ERROR;
        end else if (lit_d == '0) begin
          if (in_last_i) begin
            outcome_d = (bw_q == raw_l) ? ST_FINISHED : ST_ERROR;
          end else begin
            phase_d = PH_OFF_LO;
          end
        end else if (in_last_i) begin
          outcome_d = ST_ERROR;
        end else begin
          phase_d = PH_LITERALS;
        end
      end

      if (match_known) begin
        m4   = sat_add(ml_d, 8'd4);
        ml_d = m4;
        if (m4 > room) begin
          outcome_d = ST_ERROR;
        end else begin
          ended_d = in_last_i;
          phase_d = PH_COPY;
        end
      end
      status = outcome_d;
    end else begin
      // match copy tick
      step_o.emit = 1'b1;
      step_o.tick = 1'b1;
      bw_d = bw_inc;
      ml_d = ml_q - LEN_W'(1);
      if (ml_q == LEN_W'(1)) begin
        if (ended_q) begin
          outcome_d = (bw_inc == raw_l) ? ST_FINISHED : ST_ERROR;
        end else begin
          phase_d = PH_TOKEN;
        end
      end
      status = outcome_d;
    end

    step_o.lit       = in_byte_i;
    step_o.wr_addr   = bw_q[HIST_AW-1:0];
    step_o.rd_addr   = src[HIST_AW-1:0];
    step_o.status    = status;
    step_o.need_tick = (outcome_d == ST_RUNNING) && (phase_d == PH_COPY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q     <= '0;
      phase_q   <= PH_TOKEN;
      nib_q     <= '0;
      lit_q     <= '0;
      ml_q      <= '0;
      dist_q    <= '0;
      bw_q      <= '0;
      ended_q   <= 1'b0;
      outcome_q <= ST_RUNNING;
    end else begin
      if (cfg_we_i) begin
        raw_q <= cfg_data_i;
      end
      if (accept_i) begin
        phase_q   <= phase_d;
        nib_q     <= nib_d;
        lit_q     <= lit_d;
        ml_q      <= ml_d;
        dist_q    <= dist_d;
        bw_q      <= bw_d;
        ended_q   <= ended_d;
        outcome_q <= outcome_d;
      end
    end
  end

endmodule

### design/lz4d_out_stage.sv
module lz4d_out_stage import lz4d_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  step_t              step_i,
  output logic               free_o,
  input  logic [7:0]         rdata_i,
  output logic               we_o,
  output logic [HIST_AW-1:0] waddr_o,
  output logic [7:0]         wdata_o,
  lz4d_out_if.source         out_o
);

  logic               valid_q;
  logic               emit_q;
  logic               tick_q;
  logic [7:0]         lit_q;
  logic [HIST_AW-1:0] waddr_q;
  logic [1:0]         status_q;
  logic               need_q;
  logic               hit_q, hit_d;
  logic [7:0]         fwd_q;
  logic [7:0]         s1_byte;
  logic               fire;

  assign fire   = valid_q && out_o.ready;
  assign free_o = !valid_q || out_o.ready;

  // a tick may read the entry the previous item writes this cycle
  assign s1_byte = tick_q ? (hit_q ? fwd_q : rdata_i) : lit_q;
  assign hit_d   = valid_q && emit_q && (step_i.rd_addr == waddr_q);

  assign we_o    = fire && emit_q;
  assign waddr_o = waddr_q;
  assign wdata_o = s1_byte;

  assign out_o.valid     = valid_q;
  assign out_o.out_valid = emit_q;
  assign out_o.out_byte  = emit_q ? s1_byte : 8'h00;
  assign out_o.status    = status_q;
  assign out_o.need_tick = need_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_i) begin
      valid_q <= 1'b1;
    end else if (fire) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      emit_q   <= step_i.emit;
      tick_q   <= step_i.tick;
      lit_q    <= step_i.lit;
      waddr_q  <= step_i.wr_addr;
      status_q <= step_i.status;
      need_q   <= step_i.need_tick;
      hit_q    <= hit_d;
      fwd_q    <= s1_byte;
    end
  end

endmodule
